// File: rtl/qpx_pkg.sv
// ----------------------------------------------------------------------------
// qpx_pkg
// Shared types, constants and helpers for the query parameter extractor.
// ----------------------------------------------------------------------------
package qpx_pkg;

    // Raw value length limit and derived counter width
    localparam int MAX_RAW = 2047;
    localparam int RAW_W   = $clog2(MAX_RAW + 1);
    localparam int MAX_KEY = 8;

    // Register widths
    localparam int KEY_W  = 64;
    localparam int KLEN_W = 4;
    localparam int CAP_W  = 11;
    localparam int CIDX_W = 2;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_KEY_BYTES    = 2'd0;
    localparam logic [CIDX_W-1:0] REG_KEY_LENGTH   = 2'd1;
    localparam logic [CIDX_W-1:0] REG_OUT_CAPACITY = 2'd2;

    // Reset values of the registers
    localparam logic [KLEN_W-1:0] KLEN_RST = 4'd1;
    localparam logic [CAP_W-1:0]  CAP_RST  = 11'd2047;

    // Characters
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Output queue depth (one step adds at most three beats)
    localparam int QDEPTH = 4;
    localparam int QCNT_W = 3;

    // Scan phase, one-hot
    typedef enum logic [4:0] {
        PH_SEEK     = 5'b00001,
        PH_MATCH    = 5'b00010,
        PH_SKIP     = 5'b00100,
        PH_VALUE    = 5'b01000,
        PH_FINISHED = 5'b10000
    } t_phase;

    // Escape progress
    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_PCT   = 2'd1,
        ESC_DIGIT = 2'd2
    } t_esc;

    // One result beat
    typedef struct packed {
        logic [7:0] value_byte;
        logic       is_done;
        logic       found;
    } t_result;

    // Hex digit decode: {valid, nibble}
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// File: rtl/qpx_if.sv
// ----------------------------------------------------------------------------
// qpx_if
// Valid/ready channels: path input, decoded output, register writes.
// ----------------------------------------------------------------------------
interface qpx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] path_byte;
    logic       path_last;

    modport source (output valid, output path_byte, output path_last, input ready);
    modport sink   (input valid, input path_byte, input path_last, output ready);
endinterface

interface qpx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] value_byte;
    logic       is_done;
    logic       found;

    modport source (output valid, output value_byte, output is_done, output found,
                    input ready);
    modport sink   (input valid, input value_byte, input is_done, input found,
                    output ready);
endinterface

interface qpx_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [qpx_pkg::CIDX_W-1:0]       reg_index;
    logic [qpx_pkg::KEY_W-1:0]        wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: rtl/query_param_extract_decode_top.sv
// ----------------------------------------------------------------------------
// query_param_extract_decode_top
// Finds a key in the query part of a path and streams its percent-decoded
// value, closing each path with one done beat.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload                              | Beat accepted when
//  i_in    | in  | path_byte[7:0], path_last            | valid & ready
//  o_out   | out | value_byte[7:0], is_done, found      | valid & ready
//  i_cfg   | in  | reg_index[1:0], wr_data[63:0]        | valid & ready (always ready)
//
//  Each path beat is decoded in the cycle it is accepted; its 0..3 result
//  beats enter a 4-entry output queue and leave from the following cycle.
//  One path beat per cycle is sustained while o_out.ready holds and each yields
//  at most one result; i_in.ready drops while over one result beat is queued.
//  Synchronous active-low reset returns the scan state, the registers and
//  the queue to their reset values; no clearing pass.
// ----------------------------------------------------------------------------
module query_param_extract_decode_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qpx_in_if.sink     i_in,
    qpx_out_if.source  o_out,
    qpx_cfg_if.sink    i_cfg
);

    // Configuration registers
    logic [qpx_pkg::KEY_W-1:0]  r_key;
    logic [qpx_pkg::KLEN_W-1:0] r_klen;
    logic [qpx_pkg::CAP_W-1:0]  r_cap;

    // Scan state
    qpx_pkg::t_phase            r_phase, n_phase;
    logic [qpx_pkg::KLEN_W-1:0] r_kpos, n_kpos;
    qpx_pkg::t_esc              r_esc, n_esc;
    logic [7:0]                 r_held, n_held;
    logic [qpx_pkg::RAW_W-1:0]  r_raw, n_raw;
    logic [qpx_pkg::CAP_W-1:0]  r_emit, n_emit;

    // Output queue
    qpx_pkg::t_result           r_q [qpx_pkg::QDEPTH];
    qpx_pkg::t_result           n_q [qpx_pkg::QDEPTH];
    logic [qpx_pkg::QCNT_W-1:0] r_count, n_count;

    // Step signals
    logic                       in_fire;
    logic                       out_fire;
    logic [7:0]                 c;
    logic                       last;
    logic [qpx_pkg::KLEN_W-1:0] klen;
    logic [7:0]                 key_ch;
    logic [4:0]                 hx_c;
    logic [4:0]                 hx_held;
    logic [7:0]                 req [4];
    logic [2:0]                 nreq;
    logic                       feed_en;
    logic                       fresh;
    logic                       flush_end;
    logic                       do_flush;
    logic [qpx_pkg::CAP_W-1:0]  cap_left;
    logic [1:0]                 k;
    logic [1:0]                 lim;
    logic [1:0]                 m;
    logic                       found;
    qpx_pkg::t_result           items [3];
    logic [qpx_pkg::QCNT_W-1:0] base;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign c        = i_in.path_byte;
    assign last     = i_in.path_last;

    assign i_in.ready  = (r_count <= 3'd1);
    assign i_cfg.ready = 1'b1;

    // Clamp key length, pick the key character under test
    assign klen    = (r_klen > 4'(qpx_pkg::MAX_KEY)) ? 4'(qpx_pkg::MAX_KEY) : r_klen;
    assign key_ch  = r_key[{r_kpos[2:0], 3'b000} +: 8];
    assign hx_c    = qpx_pkg::hex_of(c);
    assign hx_held = qpx_pkg::hex_of(r_held);

    // Per-beat decode: next state and requested value bytes
    always_comb begin
        n_phase   = r_phase;
        n_kpos    = r_kpos;
        n_esc     = r_esc;
        n_held    = r_held;
        n_raw     = r_raw;
        req[0]    = 8'd0;
        req[1]    = 8'd0;
        req[2]    = 8'd0;
        req[3]    = 8'd0;
        nreq      = 3'd0;
        feed_en   = 1'b0;
        fresh     = 1'b0;
        flush_end = 1'b0;

        // Phase walk
        case (r_phase)
            qpx_pkg::PH_SEEK: begin
                if (c == qpx_pkg::CH_QMARK) begin
                    n_phase = qpx_pkg::PH_MATCH;
                    n_kpos  = '0;
                end
            end
            qpx_pkg::PH_MATCH: begin
                if (c == qpx_pkg::CH_AMP) begin
                    n_kpos = '0;
                end else if (r_kpos < klen) begin
                    if (c == key_ch) begin
                        n_kpos = r_kpos + 4'd1;
                    end else begin
                        n_phase = qpx_pkg::PH_SKIP;
                    end
                end else begin
                    n_phase = (c == qpx_pkg::CH_EQ) ? qpx_pkg::PH_VALUE : qpx_pkg::PH_SKIP;
                end
            end
            qpx_pkg::PH_SKIP: begin
                if (c == qpx_pkg::CH_AMP) begin
                    n_phase = qpx_pkg::PH_MATCH;
                    n_kpos  = '0;
                end
            end
            qpx_pkg::PH_VALUE: begin
                if (c == qpx_pkg::CH_AMP) begin
                    flush_end = 1'b1;
                    n_phase   = qpx_pkg::PH_FINISHED;
                end else if (r_raw < qpx_pkg::RAW_W'(qpx_pkg::MAX_RAW)) begin
                    n_raw   = r_raw + 1'b1;
                    feed_en = 1'b1;
                    if (n_raw >= qpx_pkg::RAW_W'(qpx_pkg::MAX_RAW)) begin
                        flush_end = 1'b1;
                        n_phase   = qpx_pkg::PH_FINISHED;
                    end
                end else begin
                    flush_end = 1'b1;
                    n_phase   = qpx_pkg::PH_FINISHED;
                end
            end
            default: begin
            end
        endcase

        // Escape decoder
        if (feed_en) begin
            case (r_esc)
                qpx_pkg::ESC_NONE: begin
                    fresh = 1'b1;
                end
                qpx_pkg::ESC_PCT: begin
                    if (hx_c[4]) begin
                        n_held = c;
                        n_esc  = qpx_pkg::ESC_DIGIT;
                    end else begin
                        req[nreq[1:0]] = qpx_pkg::CH_PCT;
                        nreq           = nreq + 3'd1;
                        n_esc          = qpx_pkg::ESC_NONE;
                        fresh          = 1'b1;
                    end
                end
                qpx_pkg::ESC_DIGIT: begin
                    if (hx_c[4]) begin
                        req[nreq[1:0]] = {(hx_held[4] ? hx_held[3:0] : 4'd0), hx_c[3:0]};
                        nreq           = nreq + 3'd1;
                        n_esc          = qpx_pkg::ESC_NONE;
                    end else begin
                        req[nreq[1:0]] = qpx_pkg::CH_PCT;
                        nreq           = nreq + 3'd1;
                        req[nreq[1:0]] = r_held;
                        nreq           = nreq + 3'd1;
                        n_esc          = qpx_pkg::ESC_NONE;
                        fresh          = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // Plain character after any escape handling
        if (fresh) begin
            if (c == qpx_pkg::CH_PCT) begin
                n_esc = qpx_pkg::ESC_PCT;
            end else begin
                req[nreq[1:0]] = (c == qpx_pkg::CH_PLUS) ? qpx_pkg::CH_SPACE : c;
                nreq           = nreq + 3'd1;
            end
        end

        // Pending escape goes out literally when the value ends
        do_flush = flush_end || (last && n_phase == qpx_pkg::PH_VALUE);
        if (do_flush) begin
            if (n_esc == qpx_pkg::ESC_PCT) begin
                req[nreq[1:0]] = qpx_pkg::CH_PCT;
                nreq           = nreq + 3'd1;
            end else if (n_esc == qpx_pkg::ESC_DIGIT) begin
                req[nreq[1:0]] = qpx_pkg::CH_PCT;
                nreq           = nreq + 3'd1;
                req[nreq[1:0]] = n_held;
                nreq           = nreq + 3'd1;
            end
            n_esc = qpx_pkg::ESC_NONE;
        end
    end

    // Beats actually sent: limited by step limit and remaining capacity
    always_comb begin
        cap_left = (r_cap > r_emit) ? (r_cap - r_emit) : '0;
        lim      = last ? 2'd2 : 2'd3;
        k        = (nreq > 3'(lim)) ? lim : nreq[1:0];
        if (cap_left < qpx_pkg::CAP_W'(k)) begin
            k = cap_left[1:0];
        end
        n_emit = r_emit + qpx_pkg::CAP_W'(k);
        m      = k + 2'(last);
        found  = (n_phase == qpx_pkg::PH_VALUE) || (n_phase == qpx_pkg::PH_FINISHED);
        for (int j = 0; j < 3; j++) begin
            if (2'(j) < k) begin
                items[j] = '{value_byte: req[j], is_done: 1'b0, found: 1'b0};
            end else begin
                items[j] = '{value_byte: 8'd0, is_done: 1'b1, found: found};
            end
        end
    end

    // Output queue: shift out on a taken beat, append new beats behind
    always_comb begin
        base = r_count - 3'(out_fire);
        for (int i = 0; i < qpx_pkg::QDEPTH; i++) begin
            if (out_fire && i < qpx_pkg::QDEPTH - 1) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
        end
        n_count = base;
        if (in_fire) begin
            for (int j = 0; j < 3; j++) begin
                if (2'(j) < m) begin
                    n_q[base[1:0] + 2'(j)] = items[j];
                end
            end
            n_count = base + 3'(m);
        end
    end

    assign o_out.valid      = (r_count != '0);
    assign o_out.value_byte = r_q[0].value_byte;
    assign o_out.is_done    = r_q[0].is_done;
    assign o_out.found      = r_q[0].found;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_klen <= qpx_pkg::KLEN_RST;
            r_cap  <= qpx_pkg::CAP_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.reg_index)
                qpx_pkg::REG_KEY_BYTES:    r_key  <= i_cfg.wr_data;
                qpx_pkg::REG_KEY_LENGTH:   r_klen <= i_cfg.wr_data[qpx_pkg::KLEN_W-1:0];
                qpx_pkg::REG_OUT_CAPACITY: r_cap  <= i_cfg.wr_data[qpx_pkg::CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Scan state; a last beat returns the path state to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= qpx_pkg::PH_SEEK;
            r_kpos  <= '0;
            r_esc   <= qpx_pkg::ESC_NONE;
            r_held  <= '0;
            r_raw   <= '0;
            r_emit  <= '0;
        end else if (in_fire) begin
            if (last) begin
                r_phase <= qpx_pkg::PH_SEEK;
                r_kpos  <= '0;
                r_esc   <= qpx_pkg::ESC_NONE;
                r_held  <= '0;
                r_raw   <= '0;
                r_emit  <= '0;
            end else begin
                r_phase <= n_phase;
                r_kpos  <= n_kpos;
                r_esc   <= n_esc;
                r_held  <= n_held;
                r_raw   <= n_raw;
                r_emit  <= n_emit;
            end
        end
    end

    // Queue count and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

// File: rtl/qpx_checker.sv
// ----------------------------------------------------------------------------
// qpx_checker
// Port-level checks for the query parameter extractor, bound to the top.
// ----------------------------------------------------------------------------
module qpx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_last,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_done,
    input logic       i_out_found
);

    // A stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat withdrawn while stalled");

    // A stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
        $stable(i_out_byte) && $stable(i_out_done) && $stable(i_out_found))
        else $error("output payload changed while stalled");

    // Value beats never carry the found flag; done beats carry a zero byte
    a_payload_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_done || !i_out_found) && (!i_out_done || i_out_byte == 8'd0))
        else $error("malformed result beat");

    // The final path beat always leaves a done beat queued
    a_last_gives_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> i_out_valid)
        else $error("no result after final path beat");

endmodule

bind query_param_extract_decode_top qpx_checker u_qpx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.path_last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.value_byte),
    .i_out_done  (o_out.is_done),
    .i_out_found (o_out.found)
);

// File: dv/query_param_extract_decode_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// query_param_extract_decode_top_tb
// Streams request paths into the query parameter extractor and checks every
// decoded value beat and done beat against an in-bench model of the scan and
// percent decoder. Directed paths cover escapes, cut-offs, key forms and
// capacity limits; random paths follow, mostly well-formed queries.
// ----------------------------------------------------------------------------
module query_param_extract_decode_top_tb;

    typedef logic [7:0] t_byte_q[$];

    localparam logic [qpx_pkg::CIDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE         = 4;
    localparam int WATCHDOG_LIMIT = 1000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    qpx_in_if  in_ch();
    qpx_out_if out_ch();
    qpx_cfg_if cfg_ch();

    query_param_extract_decode_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Register copies
    logic [qpx_pkg::KEY_W-1:0]  cfg_key;
    logic [qpx_pkg::KLEN_W-1:0] cfg_key_len;
    logic [qpx_pkg::CAP_W-1:0]  cfg_cap;

    // Scan and decode state of the model
    qpx_pkg::t_phase scan_ph;
    logic [3:0]      key_idx;
    qpx_pkg::t_esc   esc_ph;
    logic [7:0]      held_ch;
    int              raw_len;
    int              emit_len;
    int              step_n;
    int              step_max;

    qpx_pkg::t_result decoded_fifo[$];
    int               mismatch_cnt = 0;
    bit               idle_on = 1'b1;
    int               stall_left = 0;
    int               quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Decode model
    // ------------------------------------------------------------------
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic void clear_scan();
        scan_ph  = qpx_pkg::PH_SEEK;
        key_idx  = 4'd0;
        esc_ph   = qpx_pkg::ESC_NONE;
        held_ch  = 8'd0;
        raw_len  = 0;
        emit_len = 0;
    endfunction

    // Value beat, subject to capacity and the per-beat output limit
    function automatic void emit_value(input logic [7:0] b);
        qpx_pkg::t_result r;
        if (emit_len >= cfg_cap || step_n >= step_max) return;
        r.value_byte = b;
        r.is_done    = 1'b0;
        r.found      = 1'b0;
        decoded_fifo.push_back(r);
        step_n++;
        emit_len++;
    endfunction

    function automatic void decode_fresh(input logic [7:0] c);
        if (c == qpx_pkg::CH_PCT) esc_ph = qpx_pkg::ESC_PCT;
        else if (c == qpx_pkg::CH_PLUS) emit_value(qpx_pkg::CH_SPACE);
        else emit_value(c);
    endfunction

    function automatic void decode_char(input logic [7:0] c);
        int h;
        h = hex_nibble(c);
        case (esc_ph)
            qpx_pkg::ESC_NONE: decode_fresh(c);
            qpx_pkg::ESC_PCT: begin
                if (h >= 0) begin
                    held_ch = c;
                    esc_ph  = qpx_pkg::ESC_DIGIT;
                end else begin
                    // broken escape: literal '%' then decode afresh
                    emit_value(qpx_pkg::CH_PCT);
                    esc_ph = qpx_pkg::ESC_NONE;
                    decode_fresh(c);
                end
            end
            default: begin
                if (h >= 0) begin
                    emit_value(8'((hex_nibble(held_ch) << 4) | h));
                    esc_ph = qpx_pkg::ESC_NONE;
                end else begin
                    emit_value(qpx_pkg::CH_PCT);
                    emit_value(held_ch);
                    esc_ph = qpx_pkg::ESC_NONE;
                    decode_fresh(c);
                end
            end
        endcase
    endfunction

    // Pending escape goes out literally when the value ends
    function automatic void flush_pending();
        if (esc_ph == qpx_pkg::ESC_PCT) begin
            emit_value(qpx_pkg::CH_PCT);
        end else if (esc_ph == qpx_pkg::ESC_DIGIT) begin
            emit_value(qpx_pkg::CH_PCT);
            emit_value(held_ch);
        end
        esc_ph = qpx_pkg::ESC_NONE;
    endfunction

    function automatic void decode_path_char(input logic [7:0] c, input logic last);
        int               klen;
        qpx_pkg::t_result r;
        klen     = (cfg_key_len > qpx_pkg::MAX_KEY) ? qpx_pkg::MAX_KEY : cfg_key_len;
        step_n   = 0;
        step_max = last ? 2 : 3;
        case (scan_ph)
            qpx_pkg::PH_SEEK: begin
                if (c == qpx_pkg::CH_QMARK) begin
                    scan_ph = qpx_pkg::PH_MATCH;
                    key_idx = 4'd0;
                end
            end
            qpx_pkg::PH_MATCH: begin
                if (c == qpx_pkg::CH_AMP) begin
                    key_idx = 4'd0;
                end else if (key_idx < klen) begin
                    if (c == cfg_key[8*key_idx[2:0] +: 8]) key_idx++;
                    else scan_ph = qpx_pkg::PH_SKIP;
                end else begin
                    scan_ph = (c == qpx_pkg::CH_EQ) ? qpx_pkg::PH_VALUE : qpx_pkg::PH_SKIP;
                end
            end
            qpx_pkg::PH_SKIP: begin
                if (c == qpx_pkg::CH_AMP) begin
                    scan_ph = qpx_pkg::PH_MATCH;
                    key_idx = 4'd0;
                end
            end
            qpx_pkg::PH_VALUE: begin
                if (c == qpx_pkg::CH_AMP) begin
                    flush_pending();
                    scan_ph = qpx_pkg::PH_FINISHED;
                end else if (raw_len < qpx_pkg::MAX_RAW) begin
                    raw_len++;
                    decode_char(c);
                    if (raw_len >= qpx_pkg::MAX_RAW) begin
                        flush_pending();
                        scan_ph = qpx_pkg::PH_FINISHED;
                    end
                end else begin
                    flush_pending();
                    scan_ph = qpx_pkg::PH_FINISHED;
                end
            end
            default: ;
        endcase
        // done beat closes the path
        if (last) begin
            if (scan_ph == qpx_pkg::PH_VALUE) flush_pending();
            r.value_byte = 8'd0;
            r.is_done    = 1'b1;
            r.found      = (scan_ph == qpx_pkg::PH_VALUE ||
                            scan_ph == qpx_pkg::PH_FINISHED);
            decoded_fifo.push_back(r);
            clear_scan();
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stalls, result checking, watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    function automatic void note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("%t: %s", $realtime, msg);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
            note_mismatch($sformatf("%s: expected %h, got %h", name, want, got));
    endfunction

    always @(posedge i_clk) begin
        qpx_pkg::t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (decoded_fifo.size() == 0) begin
                note_mismatch($sformatf("beat with none expected: value_byte=%h is_done=%b found=%b",
                                        out_ch.value_byte, out_ch.is_done, out_ch.found));
            end else begin
                want = decoded_fifo.pop_front();
                check_field("value_byte", want.value_byte, out_ch.value_byte);
                check_field("is_done", 8'(want.is_done), 8'(out_ch.is_done));
                check_field("found", 8'(want.found), 8'(out_ch.found));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("query_param_extract_decode_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [qpx_pkg::CIDX_W-1:0] idx,
                             input logic [qpx_pkg::KEY_W-1:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            qpx_pkg::REG_KEY_BYTES:    cfg_key     = data;
            qpx_pkg::REG_KEY_LENGTH:   cfg_key_len = data[qpx_pkg::KLEN_W-1:0];
            qpx_pkg::REG_OUT_CAPACITY: cfg_cap     = data[qpx_pkg::CAP_W-1:0];
            default: ;
        endcase
    endtask

    // Upper data bits are junk; the block keeps only the field width
    task automatic set_config(input logic [qpx_pkg::KEY_W-1:0] key,
                              input logic [qpx_pkg::KLEN_W-1:0] len,
                              input logic [qpx_pkg::CAP_W-1:0] cap);
        write_reg(qpx_pkg::REG_KEY_BYTES, key);
        write_reg(qpx_pkg::REG_KEY_LENGTH, {60'({$urandom, $urandom}), len});
        write_reg(qpx_pkg::REG_OUT_CAPACITY, {53'({$urandom, $urandom}), cap});
        write_reg(REG_UNUSED, {$urandom, $urandom});
        cfg_ch.valid <= 1'b0;
    endtask

    // One path beat; valid stays high on return so beats can run back to back
    task automatic send_path_beat(input logic [7:0] ch, input logic last);
        bit gap;
        bit hold;
        gap  = idle_on && ($urandom_range(0, 5) == 0);
        hold = ($urandom_range(0, 59) == 0);
        if (gap || hold) begin
            in_ch.valid <= 1'b0;
            if (hold) do @(posedge i_clk); while (decoded_fifo.size() != 0);
            if (gap) repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.path_byte <= ch;
        in_ch.path_last <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        decode_path_char(ch, last);
    endtask

    task automatic send_path(input t_byte_q chars);
        foreach (chars[i]) send_path_beat(chars[i], i == chars.size() - 1);
    endtask

    // Release the input and let every expected beat drain
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (decoded_fifo.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_byte_q str_bytes(input string s);
        t_byte_q q;
        foreach (s[i]) q.push_back(s[i]);
        return q;
    endfunction

    function automatic logic [qpx_pkg::KEY_W-1:0] pack_key(input string s);
        logic [qpx_pkg::KEY_W-1:0] k;
        k = '0;
        foreach (s[i]) k[8*i +: 8] = s[i];
        return k;
    endfunction

    // ------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------
    function automatic logic [7:0] value_char();
        string hexset;
        hexset = "0123456789abcdefABCDEF";
        case ($urandom_range(0, 9))
            0, 1:    return qpx_pkg::CH_PCT;
            2, 3, 4: return hexset[$urandom_range(0, 21)];
            5:       return qpx_pkg::CH_PLUS;
            6:       return ($urandom_range(0, 3) == 0) ? qpx_pkg::CH_AMP : 8'h00;
            7:       return 8'($urandom);
            default: return 8'($urandom_range(8'h67, 8'h7A));
        endcase
    endfunction

    function automatic logic [qpx_pkg::KEY_W-1:0] random_key();
        logic [qpx_pkg::KEY_W-1:0] k;
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 15))
                10:      k[8*i +: 8] = 8'($urandom);
                11:      k[8*i +: 8] = qpx_pkg::CH_AMP;
                12:      k[8*i +: 8] = 8'h00;
                13:      k[8*i +: 8] = qpx_pkg::CH_EQ;
                14:      k[8*i +: 8] = qpx_pkg::CH_PCT;
                15:      k[8*i +: 8] = qpx_pkg::CH_PLUS;
                default: k[8*i +: 8] = 8'($urandom_range("a", "d"));
            endcase
        end
        return k;
    endfunction

    // Mostly queries built around the current key; some pure noise
    function automatic t_byte_q random_path();
        t_byte_q p;
        int      klen;
        int      nseg;
        klen = (cfg_key_len > qpx_pkg::MAX_KEY) ? qpx_pkg::MAX_KEY : cfg_key_len;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 12)) p.push_back(8'($urandom));
            return p;
        end
        repeat ($urandom_range(0, 2)) p.push_back(8'($urandom_range(8'h40, 8'h7E)));
        if ($urandom_range(0, 9) != 0) p.push_back(qpx_pkg::CH_QMARK);
        nseg = $urandom_range(1, 3);
        for (int s = 0; s < nseg; s++) begin
            if (s != 0) p.push_back(qpx_pkg::CH_AMP);
            // key, now and then with a wrong character
            for (int k = 0; k < klen; k++) begin
                if ($urandom_range(0, 11) == 0) p.push_back(8'($urandom_range("a", "f")));
                else p.push_back(cfg_key[8*k +: 8]);
            end
            if ($urandom_range(0, 5) != 0) p.push_back(qpx_pkg::CH_EQ);
            repeat ($urandom_range(0, 10)) p.push_back(value_char());
        end
        if (p.size() == 0) p.push_back(qpx_pkg::CH_QMARK);
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset key is one zero byte; also a path with no query at all
    task automatic test_reset_key();
        t_byte_q p;
        p = str_bytes("?_=+");
        p[1] = 8'h00;
        send_path(p);
        send_path(str_bytes("a=1"));
        wait_drained();
    endtask

    // Valid, broken and cut-off escapes, segment skip, output limit on last beat
    task automatic test_escapes();
        set_config(pack_key("a"), 4'd1, 11'd2047);
        send_path(str_bytes("?a=%4a%z%4g%4"));
        send_path(str_bytes("?b&a=%%4%"));
        wait_drained();
    endtask

    // Empty key and an over-long key length
    task automatic test_key_lengths();
        set_config(pack_key("abcdefgh"), 4'd0, 11'd2047);
        send_path(str_bytes("?=x"));
        wait_drained();
        set_config(pack_key("abcdefgh"), 4'd15, 11'd2047);
        send_path(str_bytes("?abcdefgh="));
        wait_drained();
    endtask

    task automatic test_capacity();
        set_config(pack_key("a"), 4'd0, 11'd1);
        send_path(str_bytes("?=xy"));
        wait_drained();
        set_config(pack_key("a"), 4'd0, 11'd0);
        send_path(str_bytes("?=z"));
        wait_drained();
    endtask

    task automatic test_random_paths();
        t_byte_q p;
        int      sent;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(random_key(), 4'd8, 11'd2047);
                1: set_config(random_key(), 4'd0, 11'd0);
                2: set_config(random_key(), 4'd1, 11'($urandom_range(1, 3)));
                3: set_config({$urandom, $urandom}, 4'd15, 11'($urandom));
                4: set_config(random_key(), 4'($urandom), 11'($urandom));
                default: set_config(random_key(), 4'd2, 11'd2047);
            endcase
            if (ph == 5) idle_on = 1'b0;
            sent = 0;
            while (sent < 14) begin
                p = random_path();
                send_path(p);
                sent += p.size();
            end
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.path_byte  = 8'd0;
        in_ch.path_last  = 1'b0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = qpx_pkg::REG_KEY_BYTES;
        cfg_ch.wr_data   = '0;
        cfg_key          = '0;
        cfg_key_len      = qpx_pkg::KLEN_RST;
        cfg_cap          = qpx_pkg::CAP_RST;
        clear_scan();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_key();
        test_escapes();
        test_key_lengths();
        test_capacity();
        test_random_paths();

        if (mismatch_cnt == 0 && decoded_fifo.size() == 0) begin
            $display("query_param_extract_decode_top: match");
        end else begin
            $display("query_param_extract_decode_top: mismatch");
        end
        $finish;
    end

endmodule
